### src/uat_sync_detector_threshold_macros.svh
// ----------------------------------------------------------------------------
// uat_sync_detector_threshold_macros
// Assertion helpers shared by the sync detector RTL.
// ----------------------------------------------------------------------------
`ifndef UAT_SYNC_DETECTOR_THRESHOLD_MACROS_SVH
`define UAT_SYNC_DETECTOR_THRESHOLD_MACROS_SVH

// same-cycle implication, disabled in reset
`define USD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usd assertion failed");

// next-cycle implication, disabled in reset
`define USD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usd assertion failed");

`endif

### src/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// Types and constants of the UAT sync detector.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int SYNC_LEN   = 36;
    localparam int HIST_DEPTH = 2 * SYNC_LEN;
    localparam int SAMP_W     = 16;
    localparam int SUM_W      = 22;  // holds +-36*32768
    localparam int MAG_W      = 21;  // magnitude of a sum
    localparam int AVG_W      = 17;
    localparam int ERR_W      = 6;
    localparam int FILL_W     = 7;
    localparam int HADDR_W    = 7;
    localparam int STEP_W     = 6;
    localparam int DCNT_W     = 5;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 64;

    // register map
    localparam logic [PADDR_W-1:0] ADDR_DL_WORD = 5'd0;
    localparam logic [PADDR_W-1:0] ADDR_UL_WORD = 5'd8;
    localparam logic [PADDR_W-1:0] ADDR_MAX_ERR = 5'd16;

    localparam logic [SYNC_LEN-1:0] DL_WORD_RST = 36'd63029748962;
    localparam logic [SYNC_LEN-1:0] UL_WORD_RST = 36'd5689727773;
    localparam logic [ERR_W-1:0]    MAX_ERR_RST = 6'd4;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_MATCH   = 7'b0000010,
        S_SUM     = 7'b0000100,
        S_DIV_ONE = 7'b0001000,
        S_DIV_ZER = 7'b0010000,
        S_RECHECK = 7'b0100000,
        S_OUT     = 7'b1000000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### src/usd_div.sv
// ----------------------------------------------------------------------------
// usd_div
// Iterative signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module usd_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [usd_pkg::SUM_W-1:0]      i_dividend,
    input  logic        [usd_pkg::ERR_W-1:0]      i_divisor,
    output usd_pkg::t_div_stat                    o_stat,
    output logic signed [usd_pkg::AVG_W-1:0]      o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [usd_pkg::DCNT_W-1:0]    r_cnt;
    logic [usd_pkg::MAG_W-1:0]     r_dq;
    logic [usd_pkg::ERR_W-1:0]     r_rem;
    logic [usd_pkg::ERR_W-1:0]     r_div;
    logic                          r_neg;

    logic [usd_pkg::SUM_W-1:0]     abs_in;
    logic [usd_pkg::ERR_W:0]       shifted;
    logic                          q_bit;
    logic [usd_pkg::ERR_W:0]       diff;
    logic [usd_pkg::SUM_W-1:0]     q_ext;

    assign abs_in  = i_dividend[usd_pkg::SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign shifted = {r_rem, r_dq[usd_pkg::MAG_W-1]};
    assign q_bit   = (shifted >= {1'b0, r_div});
    assign diff    = shifted - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == usd_pkg::DCNT_W'(usd_pkg::MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[usd_pkg::SUM_W-1];
            r_dq  <= abs_in[usd_pkg::MAG_W-1:0];
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[usd_pkg::ERR_W-1:0] : shifted[usd_pkg::ERR_W-1:0];
            r_dq  <= {r_dq[usd_pkg::MAG_W-2:0], q_bit};
        end
    end

    assign q_ext  = r_neg ? (~{1'b0, r_dq} + 1'b1) : {1'b0, r_dq};
    assign o_quot = q_ext[usd_pkg::AVG_W-1:0];
    assign o_stat = '{busy: r_busy, done: r_done};

endmodule

### src/uat_sync_detector_threshold.sv
// ----------------------------------------------------------------------------
// uat_sync_detector_threshold
// Sync word detector with slicing threshold for a 2x oversampled UAT stream.
// ----------------------------------------------------------------------------
// One phase sample per input beat. Until 72 samples are in, an accepted sample
// only updates the difference memory and the sync shift words. After that,
// every sample is also matched bit-serially against both sync words, and no
// new sample is taken until that work ends. A match adds:
//   - two passes over the difference memory, one entry per cycle on the
//     read port;
//   - two divisions in one shared divider (21 quotient steps each, plus
//     a start pulse and a done pulse);
//   - loading the output register.
// The output register stays full until the receiver accepts the beat, and a
// match that finishes meanwhile waits for it. A result waits in the output
// register while the next sample is taken.
// Registers: 0x00 downlink word, 0x08 uplink word, 0x10 error limit.
`include "uat_sync_detector_threshold_macros.svh"

module uat_sync_detector_threshold (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave beat: [15:0] phase_sample
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [15:0]                        i_s_tdata,
    // master beat: [31:0] start_index, [47:32] slice_center,
    // [53:48] recheck_errors, [54] sync_ok, [55] zero
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [55:0]                        o_m_tdata,
    // [0] frame_kind
    output logic                               o_m_tuser,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [usd_pkg::PADDR_W-1:0]        paddr,
    input  logic [usd_pkg::PDATA_W-1:0]        pwdata,
    output logic [usd_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int SL = usd_pkg::SYNC_LEN;

    // configuration registers
    logic [SL-1:0]              r_dl_word;
    logic [SL-1:0]              r_ul_word;
    logic [usd_pkg::ERR_W-1:0]  r_max_err;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_word <= usd_pkg::DL_WORD_RST;
            r_ul_word <= usd_pkg::UL_WORD_RST;
            r_max_err <= usd_pkg::MAX_ERR_RST;
        end else if (cfg_wr) begin
            if (paddr == usd_pkg::ADDR_DL_WORD) r_dl_word <= pwdata[SL-1:0];
            if (paddr == usd_pkg::ADDR_UL_WORD) r_ul_word <= pwdata[SL-1:0];
            if (paddr == usd_pkg::ADDR_MAX_ERR) r_max_err <= pwdata[usd_pkg::ERR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == usd_pkg::ADDR_DL_WORD) prdata[SL-1:0] = r_dl_word;
        if (paddr == usd_pkg::ADDR_UL_WORD) prdata[SL-1:0] = r_ul_word;
        if (paddr == usd_pkg::ADDR_MAX_ERR) prdata[usd_pkg::ERR_W-1:0] = r_max_err;
    end

    // state
    usd_pkg::t_state                     r_state;
    logic [usd_pkg::SAMP_W-1:0]          r_prev;
    logic [SL-1:0]                       r_even;
    logic [SL-1:0]                       r_odd;
    logic [usd_pkg::FILL_W-1:0]          r_fill;
    logic [31:0]                         r_cnt;
    logic [usd_pkg::HADDR_W-1:0]         r_wp;
    logic [usd_pkg::SAMP_W-1:0]          r_hist [0:usd_pkg::HIST_DEPTH-1];
    logic [usd_pkg::SAMP_W-1:0]          r_rdata;
    logic [usd_pkg::HADDR_W-1:0]         r_raddr;
    logic [usd_pkg::STEP_W-1:0]          r_step;
    logic [SL-1:0]                       r_xd;
    logic [SL-1:0]                       r_xu;
    logic [usd_pkg::ERR_W-1:0]           r_ed;
    logic [usd_pkg::ERR_W-1:0]           r_eu;
    logic                                r_kind;
    logic [SL-1:0]                       r_pattern;
    logic [SL-1:0]                       r_pat;
    logic                                r_pbit;
    logic signed [usd_pkg::SUM_W-1:0]    r_one_sum;
    logic signed [usd_pkg::SUM_W-1:0]    r_zero_sum;
    logic [usd_pkg::ERR_W-1:0]           r_one_n;
    logic signed [usd_pkg::AVG_W-1:0]    r_one_avg;
    logic signed [usd_pkg::AVG_W-1:0]    r_center;
    logic [usd_pkg::ERR_W-1:0]           r_errs;
    logic                                r_div_start;

    // input side
    logic                                s_acc;
    logic [usd_pkg::SAMP_W-1:0]          diff;
    logic                                dbit;
    logic [31:0]                         cnt_n;
    logic [usd_pkg::FILL_W-1:0]          fill_n;
    logic [SL-1:0]                       word_n;
    logic [usd_pkg::HADDR_W-1:0]         wp_n;
    logic [usd_pkg::HADDR_W:0]           rstart;
    logic [usd_pkg::HADDR_W:0]           rnext;

    assign o_s_tready = (r_state == usd_pkg::S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign diff       = i_s_tdata - r_prev;
    assign dbit       = !diff[usd_pkg::SAMP_W-1] && (diff != '0);
    assign cnt_n      = r_cnt + 32'd1;
    assign fill_n     = (r_fill < usd_pkg::FILL_W'(usd_pkg::HIST_DEPTH)) ?
                        r_fill + 1'b1 : r_fill;
    assign word_n     = cnt_n[0] ? {r_odd[SL-2:0], dbit} : {r_even[SL-2:0], dbit};
    assign wp_n       = (r_wp == usd_pkg::HADDR_W'(usd_pkg::HIST_DEPTH - 1)) ?
                        '0 : r_wp + 1'b1;
    // oldest sync sample sits two entries past the newest
    assign rstart     = {1'b0, r_wp} + 2'd2;
    assign rnext      = {1'b0, r_raddr} + 2'd2;

    // mismatch counts with the last bit folded in
    logic [usd_pkg::ERR_W-1:0]           ed_f;
    logic [usd_pkg::ERR_W-1:0]           eu_f;
    assign ed_f = r_ed + {{(usd_pkg::ERR_W-1){1'b0}}, r_xd[0]};
    assign eu_f = r_eu + {{(usd_pkg::ERR_W-1){1'b0}}, r_xu[0]};

    // shared divider
    usd_pkg::t_div_stat                  div_stat;
    logic signed [usd_pkg::AVG_W-1:0]    div_quot;
    logic signed [usd_pkg::SUM_W-1:0]    div_num;
    logic [usd_pkg::ERR_W-1:0]           div_den;
    logic [usd_pkg::ERR_W-1:0]           zero_n;

    assign zero_n  = usd_pkg::ERR_W'(SL) - r_one_n;
    assign div_num = (r_state == usd_pkg::S_DIV_ONE) ? r_one_sum : r_zero_sum;
    assign div_den = (r_state == usd_pkg::S_DIV_ONE) ? r_one_n : zero_n;

    usd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // center = (one_avg + zero_avg) / 2, truncated
    logic signed [usd_pkg::AVG_W-1:0]    zero_avg;
    logic signed [usd_pkg::AVG_W:0]      avg_sum;
    logic signed [usd_pkg::AVG_W:0]      avg_half;
    assign zero_avg = (zero_n == '0) ? '0 : div_quot;
    assign avg_sum  = {r_one_avg[usd_pkg::AVG_W-1], r_one_avg} +
                      {zero_avg[usd_pkg::AVG_W-1], zero_avg};
    assign avg_half = (avg_sum + {{usd_pkg::AVG_W{1'b0}}, avg_sum[usd_pkg::AVG_W]}) >>> 1;

    // stored difference, widened
    logic signed [usd_pkg::SUM_W-1:0]    rd_sum;
    logic signed [usd_pkg::AVG_W-1:0]    rd_avg;
    assign rd_sum = {{(usd_pkg::SUM_W-usd_pkg::SAMP_W){r_rdata[usd_pkg::SAMP_W-1]}}, r_rdata};
    assign rd_avg = {r_rdata[usd_pkg::SAMP_W-1], r_rdata};

    // difference memory
    always_ff @(posedge i_clk) begin
        if (s_acc && r_fill != '0) begin
            r_hist[wp_n] <= diff;
        end
        r_rdata <= r_hist[r_raddr];
    end

    // divider start pulses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= (r_state == usd_pkg::S_SUM && r_step == usd_pkg::STEP_W'(SL)) ||
                           (r_state == usd_pkg::S_DIV_ONE && div_stat.done);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= usd_pkg::S_IDLE;
            r_prev      <= '0;
            r_even      <= '0;
            r_odd       <= '0;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_wp        <= '0;
            o_m_tvalid  <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready && r_state != usd_pkg::S_OUT) o_m_tvalid <= 1'b0;

            unique case (r_state)
                usd_pkg::S_IDLE: begin
                    if (s_acc) begin
                        r_prev <= i_s_tdata;
                        if (r_fill == '0) begin
                            r_fill <= usd_pkg::FILL_W'(1);
                            r_cnt  <= '0;
                        end else begin
                            r_cnt  <= cnt_n;
                            r_wp   <= wp_n;
                            r_fill <= fill_n;
                            if (cnt_n[0]) r_odd  <= word_n;
                            else          r_even <= word_n;
                            if (fill_n == usd_pkg::FILL_W'(usd_pkg::HIST_DEPTH)) begin
                                r_xd    <= word_n ^ r_dl_word;
                                r_xu    <= word_n ^ r_ul_word;
                                r_ed    <= '0;
                                r_eu    <= '0;
                                r_step  <= '0;
                                r_state <= usd_pkg::S_MATCH;
                            end
                        end
                    end
                end
                usd_pkg::S_MATCH: begin
                    r_ed   <= ed_f;
                    r_eu   <= eu_f;
                    r_xd   <= r_xd >> 1;
                    r_xu   <= r_xu >> 1;
                    if (r_step == usd_pkg::STEP_W'(SL - 1)) begin
                        r_step     <= '0;
                        r_raddr    <= (rstart >= usd_pkg::HIST_DEPTH) ?
                                      usd_pkg::HADDR_W'(rstart - usd_pkg::HIST_DEPTH) :
                                      rstart[usd_pkg::HADDR_W-1:0];
                        r_one_sum  <= '0;
                        r_zero_sum <= '0;
                        r_one_n    <= '0;
                        if (ed_f <= r_max_err) begin
                            r_kind    <= 1'b0;
                            r_pattern <= r_dl_word;
                            r_pat     <= r_dl_word;
                            r_state   <= usd_pkg::S_SUM;
                        end else if (eu_f <= r_max_err) begin
                            r_kind    <= 1'b1;
                            r_pattern <= r_ul_word;
                            r_pat     <= r_ul_word;
                            r_state   <= usd_pkg::S_SUM;
                        end else begin
                            r_state <= usd_pkg::S_IDLE;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                usd_pkg::S_SUM: begin
                    if (r_step < usd_pkg::STEP_W'(SL)) begin
                        r_pbit  <= r_pat[SL-1];
                        r_pat   <= r_pat << 1;
                        r_raddr <= (rnext >= usd_pkg::HIST_DEPTH) ?
                                   usd_pkg::HADDR_W'(rnext - usd_pkg::HIST_DEPTH) :
                                   rnext[usd_pkg::HADDR_W-1:0];
                    end
                    if (r_step != '0) begin
                        if (r_pbit) begin
                            r_one_sum <= r_one_sum + rd_sum;
                            r_one_n   <= r_one_n + 1'b1;
                        end else begin
                            r_zero_sum <= r_zero_sum + rd_sum;
                        end
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == usd_pkg::STEP_W'(SL)) begin
                        r_state     <= usd_pkg::S_DIV_ONE;
                    end
                end
                usd_pkg::S_DIV_ONE: begin
                    if (div_stat.done) begin
                        r_one_avg   <= (r_one_n == '0) ? '0 : div_quot;
                        r_state     <= usd_pkg::S_DIV_ZER;
                    end
                end
                usd_pkg::S_DIV_ZER: begin
                    if (div_stat.done) begin
                        r_center <= avg_half[usd_pkg::AVG_W-1:0];
                        r_step   <= '0;
                        r_errs   <= '0;
                        r_pat    <= r_pattern;
                        r_raddr  <= (rstart >= usd_pkg::HIST_DEPTH) ?
                                    usd_pkg::HADDR_W'(rstart - usd_pkg::HIST_DEPTH) :
                                    rstart[usd_pkg::HADDR_W-1:0];
                        r_state  <= usd_pkg::S_RECHECK;
                    end
                end
                usd_pkg::S_RECHECK: begin
                    if (r_step < usd_pkg::STEP_W'(SL)) begin
                        r_pbit  <= r_pat[SL-1];
                        r_pat   <= r_pat << 1;
                        r_raddr <= (rnext >= usd_pkg::HIST_DEPTH) ?
                                   usd_pkg::HADDR_W'(rnext - usd_pkg::HIST_DEPTH) :
                                   rnext[usd_pkg::HADDR_W-1:0];
                    end
                    if (r_step != '0) begin
                        if (r_pbit ? (rd_avg < r_center) : (rd_avg > r_center)) begin
                            r_errs <= r_errs + 1'b1;
                        end
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == usd_pkg::STEP_W'(SL)) r_state <= usd_pkg::S_OUT;
                end
                usd_pkg::S_OUT: begin
                    if (!o_m_tvalid || i_m_tready) begin
                        o_m_tvalid <= 1'b1;
                        r_state    <= usd_pkg::S_IDLE;
                    end
                end
                default: r_state <= usd_pkg::S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == usd_pkg::S_OUT && (!o_m_tvalid || i_m_tready)) begin
            o_m_tuser         <= r_kind;
            o_m_tdata[31:0]   <= r_cnt - 32'(usd_pkg::HIST_DEPTH - 1);
            o_m_tdata[47:32]  <= r_center[usd_pkg::SAMP_W-1:0];
            o_m_tdata[53:48]  <= r_errs;
            o_m_tdata[54]     <= (r_errs <= r_max_err);
            o_m_tdata[55]     <= 1'b0;
        end
    end

    // checks
    `USD_ASSERT_NEXT(a_first_sample, i_clk, i_rst_n, s_acc && r_fill == '0, r_fill == 1)
    `USD_ASSERT_NEXT(a_sum_to_div, i_clk, i_rst_n, r_state == usd_pkg::S_SUM && r_step == usd_pkg::STEP_W'(SL), r_state == usd_pkg::S_DIV_ONE && r_div_start)
    `USD_ASSERT_NOW(a_div_done_place, i_clk, i_rst_n, div_stat.done, r_state == usd_pkg::S_DIV_ONE || r_state == usd_pkg::S_DIV_ZER)
    `USD_ASSERT_NOW(a_err_range, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[53:48] <= 6'd36)

endmodule
